// File: design/sart_pkg.sv
// Package for the sorted address range table.
// Holds status and action codes, controller command/status structs. No dependencies.
package sart_pkg;
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_REJECTED  = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_FOUND     = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic load;     // capture the input item
        logic scan;     // evaluate compare cells and register results
        logic insert;   // shift and write the new entry
    } t_cmd;

    typedef struct packed {
        logic is_lookup;
        logic can_insert;
    } t_stat;
endpackage

// File: design/sorted_address_range_table.sv
// Sorted address range table: add ranges, look up the range holding an address.
// A lookup result is valid after the scan state, an add result after the scan
// and insert states. One item at a time: the next item is accepted the cycle
// after the result is taken, following the controller's load/scan/insert sequence.
// Reset (synchronous, active low) empties the table and idles the controller.
module sorted_address_range_table #(
    parameter int TABLE_DEPTH    = 16,
    parameter int REGION_ID_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [63:0] i_range_base,
    input  logic [63:0] i_range_span,
    input  logic [15:0] i_region_id,
    input  logic [63:0] i_lookup_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [63:0] o_hit_base,
    output logic [63:0] o_hit_span,
    output logic [15:0] o_hit_region
);
    sart_pkg::t_cmd  cmd;
    sart_pkg::t_stat stat;

    sart_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .o_cmd(cmd), .i_stat(stat)
    );

    sart_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .REGION_ID_BITS(REGION_ID_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_action(i_action), .i_range_base(i_range_base),
        .i_range_span(i_range_span), .i_region_id(i_region_id),
        .i_lookup_address(i_lookup_address), .o_status(o_status),
        .o_hit_base(o_hit_base), .o_hit_span(o_hit_span),
        .o_hit_region(o_hit_region)
    );
endmodule

// File: design/sart_datapath.sv
// Datapath: entry registers, one compare cell per entry, result register.
// Depends on sart_pkg.
module sart_datapath #(
    parameter int TABLE_DEPTH    = 16,
    parameter int REGION_ID_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sart_pkg::t_cmd         i_cmd,
    output sart_pkg::t_stat        o_stat,
    input  logic                   i_action,
    input  logic [63:0]            i_range_base,
    input  logic [63:0]            i_range_span,
    input  logic [15:0]            i_region_id,
    input  logic [63:0]            i_lookup_address,
    output logic [2:0]             o_status,
    output logic [63:0]            o_hit_base,
    output logic [63:0]            o_hit_span,
    output logic [15:0]            o_hit_region
);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    logic [63:0]             r_base [TABLE_DEPTH];
    logic [63:0]             r_span [TABLE_DEPTH];
    logic [REGION_ID_BITS-1:0] r_reg [TABLE_DEPTH];
    logic [CW-1:0]           r_count, n_count;

    logic                      r_act;
    logic [63:0]               r_ib, r_is, r_addr;
    logic [REGION_ID_BITS-1:0] r_ir;

    logic [TABLE_DEPTH-1:0] valid_v, lt_v, le_v, dup_v;
    logic [2:0]             n_status;
    logic                   r_ins_ok;

    // per-entry compare cells
    always_comb begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            valid_v[k] = (CW'(k) < r_count);
            lt_v[k]    = valid_v[k] && (r_base[k] < r_ib);
            le_v[k]    = valid_v[k] && (r_base[k] <= r_addr);
            dup_v[k]   = valid_v[k] && (r_base[k] == r_ib) && (r_reg[k] == r_ir);
        end
    end

    // bases are sorted, so le_v is a prefix; the last set bit is the candidate
    logic [IW-1:0] cand;
    logic          cand_ok;
    always_comb begin
        cand    = '0;
        cand_ok = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (le_v[k]) begin
                cand    = IW'(k);
                cand_ok = 1'b1;
            end
        end
    end

    logic hit;
    assign hit = cand_ok && ((r_addr - r_base[cand]) < r_span[cand]);

    always_comb begin
        if (r_act == sart_pkg::ACT_LOOKUP) begin
            n_status = hit ? sart_pkg::ST_FOUND : sart_pkg::ST_NOT_FOUND;
        end else if (r_is == '0 || r_ir == '0) begin
            n_status = sart_pkg::ST_REJECTED;
        end else if (|dup_v) begin
            n_status = sart_pkg::ST_DUPLICATE;
        end else if (r_count >= CW'(TABLE_DEPTH)) begin
            n_status = sart_pkg::ST_FULL;
        end else begin
            n_status = sart_pkg::ST_ADDED;
        end
    end

    assign o_stat.is_lookup  = r_act;
    assign o_stat.can_insert = r_ins_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= i_action;
            r_ib   <= i_range_base;
            r_is   <= i_range_span;
            r_ir   <= REGION_ID_BITS'(i_region_id);
            r_addr <= i_lookup_address;
        end
        if (i_cmd.scan) begin
            o_status     <= n_status;
            r_ins_ok     <= (n_status == sart_pkg::ST_ADDED) &&
                            (r_act == sart_pkg::ACT_ADD);
            o_hit_base   <= (r_act == sart_pkg::ACT_LOOKUP && hit) ? r_base[cand] : '0;
            o_hit_span   <= (r_act == sart_pkg::ACT_LOOKUP && hit) ? r_span[cand] : '0;
            o_hit_region <= (r_act == sart_pkg::ACT_LOOKUP && hit) ?
                            16'(r_reg[cand]) : '0;
        end
    end

    // shift entries at or above the insert point up one place and write the new entry there
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                if (!lt_v[k]) begin
                    if (k == 0 || lt_v[(k == 0) ? 0 : k-1]) begin
                        r_base[k] <= r_ib;
                        r_span[k] <= r_is;
                        r_reg[k]  <= r_ir;
                    end else begin
                        r_base[k] <= r_base[(k == 0) ? 0 : k-1];
                        r_span[k] <= r_span[(k == 0) ? 0 : k-1];
                        r_reg[k]  <= r_reg[(k == 0) ? 0 : k-1];
                    end
                end
            end
        end
    end

    assign n_count = r_count + CW'(1);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.insert) begin
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH)) else $error("entry count overflow");
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow table");
    a_insert_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> r_ins_ok && r_count < CW'(TABLE_DEPTH))
        else $error("insert into full table");
`endif
endmodule

// File: design/sart_ctrl.sv
// Controller state machine: load, scan, optional insert, hold result.
// Depends on sart_pkg.
module sart_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output sart_pkg::t_cmd  o_cmd,
    input  sart_pkg::t_stat i_stat
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state, n_state;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd.load   = o_ready && i_valid;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.insert = (r_state == S_INS) && i_stat.can_insert;
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_SCAN;
            S_SCAN: n_state = i_stat.is_lookup ? S_OUT : S_INS;
            S_INS:  n_state = S_OUT;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_SCAN) else $error("load without scan");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_ins_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INS |-> $past(r_state) == S_SCAN) else $error("bad insert");
`endif
endmodule
